/* rtl/reb_pkg.sv */
// ============================================================================
// reb_pkg
// Shared types and constants for the rotary encoder and button event block.
// ============================================================================
package reb_pkg;

    // Width of the signed pending step count.
    localparam int STEP_BITS = 8;
    // Width of the held-tick counter.
    localparam int TICK_BITS = 16;
    // Width of the long press threshold register.
    localparam int LP_BITS = 16;
    // Reset value of the long press threshold.
    localparam logic [LP_BITS-1:0] LONG_PRESS_RESET = LP_BITS'(1000);

    // Width used when comparing the held ticks against the threshold.
    localparam int CMP_BITS = (TICK_BITS > LP_BITS) ? TICK_BITS : LP_BITS;

    localparam logic signed [STEP_BITS-1:0] STEP_MAX = {1'b0, {(STEP_BITS-1){1'b1}}};
    localparam logic signed [STEP_BITS-1:0] STEP_MIN = {1'b1, {(STEP_BITS-1){1'b0}}};
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Stream data widths, padded to whole bytes, and the user field width.
    localparam int S_DATA_BITS = 8;
    localparam int M_DATA_BITS = 8;
    localparam int S_USER_BITS = 2;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ENC  = 2'd1,
        ACT_BTN  = 2'd2,
        ACT_POLL = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_CW    = 3'd1,
        EV_CCW   = 3'd2,
        EV_SHORT = 3'd3,
        EV_LONG  = 3'd4
    } event_t;

    // One request as held in the input register.
    typedef struct packed {
        action_t action;
        logic    clk_level;
        logic    dt_level;
        logic    switch_level;
    } item_t;

    // Result handed from the event logic to the result register.
    typedef struct packed {
        logic   valid;
        event_t event_res;
    } result_t;

endpackage

/* rtl/reb_in_stage.sv */
// ============================================================================
// reb_in_stage
// Input register holding one accepted request until the event logic takes it.
// ============================================================================
module reb_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  reb_pkg::item_t load_item,
    input  logic           drain,
    output logic           item_valid,
    output reb_pkg::item_t item
);
    import reb_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/reb_event_logic.sv */
// ============================================================================
// reb_event_logic
// Encoder, button and tick state with the update that a request makes to it.
// ============================================================================
module reb_event_logic
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  reb_pkg::item_t                item,
    input  logic                          cfg_we,
    input  logic [reb_pkg::LP_BITS-1:0]   cfg_wdata,
    output reb_pkg::result_t              result
);
    import reb_pkg::*;

    logic                        last_clk_reg;
    logic                        last_clk_next;
    logic signed [STEP_BITS-1:0] pending_steps_reg;
    logic signed [STEP_BITS-1:0] pending_steps_next;
    logic                        button_down_reg;
    logic                        button_down_next;
    logic [TICK_BITS-1:0]        press_ticks_reg;
    logic [TICK_BITS-1:0]        press_ticks_next;
    logic                        press_unreported_reg;
    logic                        press_unreported_next;
    logic [LP_BITS-1:0]          long_press_reg;
    logic                        is_long;
    logic                        steps_pos;
    logic                        steps_neg;

    assign is_long   = CMP_BITS'(press_ticks_reg) > CMP_BITS'(long_press_reg);
    assign steps_neg = pending_steps_reg[STEP_BITS-1];
    assign steps_pos = !steps_neg && (pending_steps_reg != '0);

    always_comb
    begin
        last_clk_next         = last_clk_reg;
        pending_steps_next    = pending_steps_reg;
        button_down_next      = button_down_reg;
        press_ticks_next      = press_ticks_reg;
        press_unreported_next = press_unreported_reg;
        result.valid          = 1'b0;
        result.event_res      = EV_NONE;
        if (fire)
        begin
            case (item.action)
                ACT_TICK:
                begin
                    if (button_down_reg && (press_ticks_reg != TICK_MAX))
                    begin
                        press_ticks_next = press_ticks_reg + 1'b1;
                    end
                end
                ACT_ENC:
                begin
                    // Only a rising CLK edge moves the count; DT gives the direction.
                    if (item.clk_level && !last_clk_reg)
                    begin
                        if (item.dt_level)
                        begin
                            if (pending_steps_reg != STEP_MIN)
                            begin
                                pending_steps_next = pending_steps_reg - 1'b1;
                            end
                        end
                        else if (pending_steps_reg != STEP_MAX)
                        begin
                            pending_steps_next = pending_steps_reg + 1'b1;
                        end
                    end
                    last_clk_next = item.clk_level;
                end
                ACT_BTN:
                begin
                    if (!item.switch_level && !button_down_reg)
                    begin
                        button_down_next      = 1'b1;
                        press_ticks_next      = '0;
                        press_unreported_next = 1'b1;
                    end
                    else if (item.switch_level && button_down_reg)
                    begin
                        button_down_next = 1'b0;
                    end
                end
                ACT_POLL:
                begin
                    result.valid = 1'b1;
                    // A press in progress holds back all events until release.
                    if (press_unreported_reg)
                    begin
                        if (!button_down_reg)
                        begin
                            press_unreported_next = 1'b0;
                            result.event_res      = is_long ? EV_LONG : EV_SHORT;
                        end
                    end
                    else if (steps_pos)
                    begin
                        pending_steps_next = pending_steps_reg - 1'b1;
                        result.event_res   = EV_CW;
                    end
                    else if (steps_neg)
                    begin
                        pending_steps_next = pending_steps_reg + 1'b1;
                        result.event_res   = EV_CCW;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_clk_reg         <= 1'b0;
            pending_steps_reg    <= '0;
            button_down_reg      <= 1'b0;
            press_ticks_reg      <= '0;
            press_unreported_reg <= 1'b0;
            long_press_reg       <= LONG_PRESS_RESET;
        end
        else
        begin
            last_clk_reg         <= last_clk_next;
            pending_steps_reg    <= pending_steps_next;
            button_down_reg      <= button_down_next;
            press_ticks_reg      <= press_ticks_next;
            press_unreported_reg <= press_unreported_next;
            if (cfg_we)
            begin
                long_press_reg <= cfg_wdata;
            end
        end
    end

endmodule

/* rtl/reb_out_stage.sv */
// ============================================================================
// reb_out_stage
// Result register that holds one event until the downstream side takes it.
// ============================================================================
module reb_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  reb_pkg::result_t result,
    input  logic             taken,
    output logic             out_valid,
    output reb_pkg::event_t  out_event
);
    import reb_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t event_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (result.valid)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            event_reg <= result.event_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_event = event_reg;

endmodule

/* rtl/rotary_encoder_button_events_core.sv */
// ============================================================================
// rotary_encoder_button_events_core
// Turns encoder pin samples, button samples and timer ticks into user events.
// ============================================================================
// Each request on the slave stream is a timer tick, a sample of the encoder
// CLK and DT pins, a sample of the button pin, or a poll. Only a poll makes a
// result on the master stream. The result is a finished press first (long
// when its held ticks exceed long_press_ticks, short otherwise), else one
// pending clockwise or counter-clockwise step, else "none". While a press is
// still held and unreported, a poll returns "none" and the steps stay
// pending. The block takes one request per cycle. A request is loaded into
// the input register at the accepting edge. It is applied to the state at
// the edge at which it leaves the input register, and a poll's event is
// loaded into the result register at that same edge, from where m_tvalid
// offers it. Intake stops only when a poll waits in the input register
// while the result register is full and not being taken; ticks and pin
// samples never wait on the master side. long_press_ticks is written
// through cfg_we and cfg_wdata; the user must write it only while no request
// is in flight, and the block itself does not enforce this. It resets to 1000.
module rotary_encoder_button_events_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration: long press threshold.
    input  logic                               cfg_we,
    input  logic [reb_pkg::LP_BITS-1:0]        cfg_wdata,
    // Slave stream: request input.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: [0] clk_level, [1] dt_level, [2] switch_level, rest zero.
    input  logic [reb_pkg::S_DATA_BITS-1:0]    s_tdata,
    // s_tuser: [1:0] action.
    input  logic [reb_pkg::S_USER_BITS-1:0]    s_tuser,
    // Master stream: event output.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [2:0] event_res, rest zero.
    output logic [reb_pkg::M_DATA_BITS-1:0]    m_tdata
);
    import reb_pkg::*;

    item_t   load_item;
    item_t   item;
    logic    item_valid;
    logic    item_is_poll;
    logic    out_room;
    logic    fire;
    result_t result;
    event_t  out_event;
    logic    s_accept;
    logic    m_taken;

    assign load_item.action       = action_t'(s_tuser);
    assign load_item.clk_level    = s_tdata[0];
    assign load_item.dt_level     = s_tdata[1];
    assign load_item.switch_level = s_tdata[2];

    // A held request moves on unless it is a poll facing a full result register that is not being taken.
    assign m_taken      = m_tvalid && m_tready;
    assign out_room     = !m_tvalid || m_tready;
    assign item_is_poll = (item.action == ACT_POLL);
    assign fire         = item_valid && (!item_is_poll || out_room);
    assign s_tready     = !item_valid || fire;
    assign s_accept     = s_tvalid && s_tready;

    reb_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s_accept),
        .load_item  (load_item),
        .drain      (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    reb_event_logic u_event_logic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

    reb_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .taken     (m_taken),
        .out_valid (m_tvalid),
        .out_event (out_event)
    );

    assign m_tdata = M_DATA_BITS'(out_event);

`ifndef NO_ASSERTIONS
    // A new event is only produced when the result register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> out_room)
        else $error("event produced while result register is blocked");

    // A poll blocked by the master side must stall the slave side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_is_poll && m_tvalid && !m_tready) |-> !s_tready)
        else $error("request accepted past a blocked poll");

    // Every processed poll shows up as a valid event on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_is_poll) |=> m_tvalid)
        else $error("poll lost between stages");

    // Only defined event codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= M_DATA_BITS'(EV_LONG)))
        else $error("undefined event code on output");
`endif

endmodule

/* sim/rotary_encoder_button_events_core_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// rotary_encoder_button_events_core_test
// Self-checking bench for the encoder and button event block. Requests are
// sent on the slave stream and tracked by a behavioral copy of the block. That
// copy holds its own step count, press timer and long press threshold, and
// each poll queues the event it owes. Events on the master stream are checked
// in order against that queue while both sides idle at random but in the last phase.
// ============================================================================
module rotary_encoder_button_events_core_test;

    import reb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_QUOTA  = 55;
    localparam int LONG_STALL   = 150;
    // Small threshold for the presses held one tick past it and exactly at it.
    localparam logic [LP_BITS-1:0] EDGE_THRESHOLD = LP_BITS'(6);

    // One line of the directed script. When known is set, the event for a poll
    // is typed in and replaces the tracked one.
    typedef struct packed {
        action_t act;
        logic    clk_lv;
        logic    dt_lv;
        logic    sw_lv;
        logic    known;
        event_t  ev;
    } script_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [LP_BITS-1:0]      cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_DATA_BITS-1:0]  s_tdata;
    logic [S_USER_BITS-1:0]  s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_DATA_BITS-1:0]  m_tdata;

    // Behavioral copy of the block state, all at reset values.
    logic                        seen_clk     = 1'b0;
    logic signed [STEP_BITS-1:0] step_count   = '0;
    logic                        held         = 1'b0;
    logic [TICK_BITS-1:0]        held_ticks   = '0;
    logic                        press_open   = 1'b0;
    logic [LP_BITS-1:0]          lp_threshold = LONG_PRESS_RESET;

    event_t owed_events [$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    bit     sender_idles = 1'b1;
    bit     calm = 1'b0;
    bit     long_stall_req = 1'b0;

    script_row_t script [23] = '{
        {ACT_POLL, 1'b0, 1'b0, 1'b1, 1'b1, EV_NONE},   // poll straight after reset
        {ACT_TICK, 1'b1, 1'b1, 1'b1, 1'b0, EV_NONE},   // tick with no press
        {ACT_ENC,  1'b1, 1'b0, 1'b0, 1'b0, EV_NONE},   // rising CLK, DT low
        {ACT_ENC,  1'b1, 1'b1, 1'b1, 1'b0, EV_NONE},   // CLK stays high
        {ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b1, EV_CW},
        {ACT_POLL, 1'b1, 1'b1, 1'b1, 1'b1, EV_NONE},   // nothing pending
        {ACT_ENC,  1'b0, 1'b1, 1'b0, 1'b0, EV_NONE},
        {ACT_ENC,  1'b1, 1'b1, 1'b0, 1'b0, EV_NONE},   // rising CLK, DT high
        {ACT_ENC,  1'b0, 1'b0, 1'b1, 1'b0, EV_NONE},
        {ACT_ENC,  1'b1, 1'b1, 1'b1, 1'b0, EV_NONE},
        {ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b1, EV_CCW},
        {ACT_BTN,  1'b0, 1'b0, 1'b0, 1'b0, EV_NONE},   // press
        {ACT_BTN,  1'b1, 1'b1, 1'b0, 1'b0, EV_NONE},   // low again while held
        {ACT_TICK, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE},
        {ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b1, EV_NONE},   // press still held
        {ACT_BTN,  1'b0, 1'b0, 1'b1, 1'b0, EV_NONE},   // release
        {ACT_BTN,  1'b1, 1'b0, 1'b1, 1'b0, EV_NONE},   // high again while released
        {ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b1, EV_SHORT},
        {ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b1, EV_CCW},    // step kept during the press
        {ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b1, EV_NONE},
        {ACT_BTN,  1'b0, 1'b0, 1'b0, 1'b0, EV_NONE},   // press with no ticks
        {ACT_BTN,  1'b0, 1'b0, 1'b1, 1'b0, EV_NONE},
        {ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b1, EV_SHORT}
    };

    rotary_encoder_button_events_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // One random pin level.
    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Applies one accepted request to the tracked state. A poll always owes
    // exactly one event; other requests owe none.
    task automatic compute_event(input action_t act, input logic clk_lv, input logic dt_lv,
                                 input logic sw_lv, output bit makes, output event_t ev);
        makes = 1'b0;
        ev    = EV_NONE;
        case (act)
            ACT_TICK:
                if (held && held_ticks != TICK_MAX)
                    held_ticks = held_ticks + 1'b1;
            ACT_ENC:
            begin
                if (clk_lv && !seen_clk)
                begin
                    if (dt_lv)
                    begin
                        if (step_count != STEP_MIN)
                            step_count = step_count - 1'b1;
                    end
                    else if (step_count != STEP_MAX)
                        step_count = step_count + 1'b1;
                end
                seen_clk = clk_lv;
            end
            ACT_BTN:
            begin
                if (!sw_lv && !held)
                begin
                    held       = 1'b1;
                    held_ticks = '0;
                    press_open = 1'b1;
                end
                else if (sw_lv && held)
                    held = 1'b0;
            end
            default:
            begin
                makes = 1'b1;
                if (press_open)
                begin
                    // A press that is still held blocks the steps as well.
                    if (!held)
                    begin
                        press_open = 1'b0;
                        ev = (held_ticks > lp_threshold) ? EV_LONG : EV_SHORT;
                    end
                end
                else if (step_count > 0)
                begin
                    step_count = step_count - 1'b1;
                    ev = EV_CW;
                end
                else if (step_count < 0)
                begin
                    step_count = step_count + 1'b1;
                    ev = EV_CCW;
                end
            end
        endcase
    endtask

    // Offers one request and holds it until the block takes it. s_tvalid stays
    // high afterwards so that back-to-back requests need no gap.
    task automatic send_request(input action_t act, input logic clk_lv, input logic dt_lv,
                                input logic sw_lv, input logic known, input event_t known_ev);
        bit     makes;
        event_t ev;
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_DATA_BITS-3){1'b0}}, sw_lv, dt_lv, clk_lv};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        compute_event(act, clk_lv, dt_lv, sw_lv, makes, ev);
        if (makes)
            owed_events.push_back(known ? known_ev : ev);
    endtask

    // Stops offering and waits until every owed event has come out, then lets
    // the pipeline settle.
    task automatic pause_sender();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (owed_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [LP_BITS-1:0] value);
        pause_sender();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        lp_threshold = value;
    endtask

    // Event receiver: checks each taken event and drives m_tready with short
    // random stalls, plus one long stall on request.
    initial
    begin
        int     stall_left;
        event_t want;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (owed_events.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected event, expected none, actual %0d",
                             $time, m_tdata);
                end
                else
                begin
                    want = owed_events.pop_front();
                    if (m_tdata !== M_DATA_BITS'(want))
                    begin
                        mismatch_count++;
                        $display("%0t: event_res mismatch, expected %0d, actual %0d",
                                 $time, want, m_tdata);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left = LONG_STALL - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Request sender.
    initial
    begin
        int   i;
        int   phase;
        int   n;
        int   k;
        int   pick;
        int   counted;
        logic dir;
        logic [LP_BITS-1:0] setting;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_TICK;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
            send_request(script[r].act, script[r].clk_lv, script[r].dt_lv, script[r].sw_lv,
                         script[r].known, script[r].ev);

        // Presses held one tick past a small threshold and exactly at it.
        write_threshold(EDGE_THRESHOLD);
        for (i = 0; i < 2; i++)
        begin
            send_request(ACT_BTN, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE);
            repeat (int'(EDGE_THRESHOLD) + 1 - i)
                send_request(ACT_TICK, rand_bit(), rand_bit(), rand_bit(), 1'b0, EV_NONE);
            send_request(ACT_BTN, 1'b0, 1'b0, 1'b1, 1'b0, EV_NONE);
            send_request(ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE);
        end

        // Step count driven past its upper end, then drained by polls.
        repeat (130)
        begin
            send_request(ACT_ENC, 1'b0, rand_bit(), rand_bit(), 1'b0, EV_NONE);
            send_request(ACT_ENC, 1'b1, 1'b0, rand_bit(), 1'b0, EV_NONE);
        end
        repeat (130)
            send_request(ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE);

        // Random gestures under several thresholds; the last phase runs
        // without idling on either side.
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: setting = '0;
                1: setting = TICK_MAX;
                2: setting = LP_BITS'(5);
                3: setting = LP_BITS'($urandom_range(1, 12));
                default: setting = LP_BITS'(2);
            endcase
            write_threshold(setting);
            if (phase == 4)
            begin
                calm = 1'b1;
                sender_idles = 1'b0;
            end
            if (phase == 0)
            begin
                // Receiver holds off while polls keep coming, so intake stalls.
                long_stall_req = 1'b1;
                repeat (30)
                    send_request(ACT_POLL, rand_bit(), rand_bit(), rand_bit(),
                                 1'b0, EV_NONE);
            end
            counted = 0;
            while (counted < PHASE_QUOTA)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    // A turn of a few detents in one direction.
                    n   = $urandom_range(1, 4);
                    dir = rand_bit();
                    repeat (n)
                    begin
                        send_request(ACT_ENC, 1'b0, rand_bit(), rand_bit(), 1'b0, EV_NONE);
                        send_request(ACT_ENC, 1'b1, dir, rand_bit(), 1'b0, EV_NONE);
                    end
                    counted += 2 * n;
                end
                else if (pick < 55)
                begin
                    // A press with a random hold time, now and then polled
                    // or turned while it is held.
                    send_request(ACT_BTN, rand_bit(), rand_bit(), 1'b0, 1'b0, EV_NONE);
                    k = $urandom_range(0, 14);
                    repeat (k)
                    begin
                        send_request(ACT_TICK, rand_bit(), rand_bit(), rand_bit(),
                                     1'b0, EV_NONE);
                        if ($urandom_range(0, 7) == 0)
                            send_request(ACT_POLL, 1'b0, 1'b0, 1'b0, 1'b0, EV_NONE);
                        if ($urandom_range(0, 9) == 0)
                            send_request(ACT_ENC, rand_bit(), rand_bit(), rand_bit(),
                                         1'b0, EV_NONE);
                    end
                    send_request(ACT_BTN, rand_bit(), rand_bit(), 1'b1, 1'b0, EV_NONE);
                    counted += k + 2;
                end
                else if (pick < 85)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send_request(ACT_POLL, rand_bit(), rand_bit(), rand_bit(),
                                     1'b0, EV_NONE);
                    counted += n;
                end
                else
                begin
                    // Unstructured requests: stray levels, lone ticks.
                    repeat ($urandom_range(1, 3))
                        send_request(action_t'(2'($urandom_range(0, 3))), rand_bit(),
                                     rand_bit(), rand_bit(), 1'b0, EV_NONE);
                end
            end
        end

        pause_sender();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
